>>> rtl/sisp_pkg.sv
package sisp_pkg;

    localparam int NumSources = 256;
    localparam int MaxHistory = 8;
    localparam int MaxDistance = 16;
    localparam int SrcW = 8;
    localparam int PageW = 52;
    localparam int DomW = 16;
    localparam int HistIdxW = 3;
    localparam int CntW = 4;
    localparam int FillW = 5;
    localparam int FifoIdxW = 4;
    localparam int HAddrW = SrcW + HistIdxW;

    localparam logic [0:0] CfgHistoryLength = 1'b0;
    localparam logic [0:0] CfgPrefetchDistance = 1'b1;

    localparam logic [1:0] PriorNone = 2'd0;
    localparam logic [1:0] PriorHit = 2'd1;
    localparam logic [1:0] PriorMiss = 2'd2;

    typedef struct packed {
        logic [SrcW-1:0]  source_id;
        logic [PageW-1:0] page_address;
        logic [DomW-1:0]  domain_id;
    } t_req;

    typedef struct packed {
        logic             prediction_made;
        logic [SrcW-1:0]  predicted_source;
        logic [PageW-1:0] prefetch_page;
        logic [DomW-1:0]  prefetch_domain;
        logic             last_in_run;
        logic             page_was_recent;
        logic [1:0]       prior_prediction;
    } t_rsp;

    // one entry of the per-source table
    typedef struct packed {
        logic                succ_valid;
        logic [SrcW-1:0]     succ_src;
        logic [CntW-1:0]     count;
        logic [HistIdxW-1:0] oldest;
    } t_smeta;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_META,
        ST_SEARCH,
        ST_SEARCH_CHK,
        ST_WRITE,
        ST_SUCC,
        ST_RD,
        ST_LOAD,
        ST_EMIT,
        ST_LEARN,
        ST_SHIFT,
        ST_CLEAR
    } t_state;

endpackage

>>> rtl/source_id_successor_prefetch_predictor.sv
// Channel | Direction | Handshake      | Payload
// req     | in        | valid / stall  | t_req (source, page, domain)
// rsp     | out       | valid / stall  | t_rsp, 1..8 per request
// cfg     | in        | valid / ready  | index (1 bit), data (5 bits)
// A request is handled serially; the single history memory port, the registered
// source table read and the serial FIFO shift set how long it takes, plus any
// output stalls. The FIFO shift only runs once the source FIFO is full.
// Reset is synchronous; after it a clearing pass zeroes the source table with
// the request stall held. A stalled result holds the emit state.
module source_id_successor_prefetch_predictor
    import sisp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    output logic         o_req_stall,
    input  t_req         i_req,
    output logic         o_rsp_valid,
    input  logic         i_rsp_stall,
    output t_rsp         o_rsp,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [4:0]   i_cfg_data
);

    // config
    logic [CntW-1:0]  r_hist_len;
    logic [FillW-1:0] r_pf_dist;

    // per-source table memory
    t_smeta            r_smem [NumSources];
    t_smeta            r_srd;
    logic [SrcW-1:0]   r_clr, n_clr;

    // history memory
    logic [PageW+DomW-1:0] r_hmem [NumSources*MaxHistory];
    logic [PageW+DomW-1:0] r_hrd;

    // source FIFO and scalars
    logic [SrcW-1:0]  r_fifo [MaxDistance];
    logic [FillW-1:0] r_fill, n_fill;
    logic [SrcW-1:0]  r_earlier, n_earlier;
    logic             r_earlier_v, n_earlier_v;
    logic [SrcW-1:0]  r_pend, n_pend;
    logic             r_pend_v, n_pend_v;

    // per-request
    t_state            r_state, n_state;
    t_req              r_req;
    logic [CntW-1:0]   r_cnt;
    logic [HistIdxW-1:0] r_old;
    logic [CntW-1:0]   r_i, n_i;
    logic              r_recent, n_recent;
    logic [1:0]        r_prior;
    logic              r_made;
    logic [SrcW-1:0]   r_succ;
    logic [CntW-1:0]   r_sc;
    logic [HistIdxW-1:0] r_so;
    logic [FillW-1:0]  r_sh, n_sh;
    logic [FillW-1:0]  r_start;
    t_rsp              r_rsp;

    logic [CntW-1:0]  len_c;
    logic [FillW-1:0] dist_c;
    logic [FillW-1:0] start_c;
    logic [SrcW-1:0]  cur;
    logic             learn_c;

    assign cur = r_req.source_id;
    assign len_c = (r_hist_len == '0) ? CntW'(1)
                 : (r_hist_len > CntW'(MaxHistory)) ? CntW'(MaxHistory) : r_hist_len;
    assign dist_c = (r_pf_dist == '0) ? FillW'(1)
                  : (r_pf_dist > FillW'(MaxDistance)) ? FillW'(MaxDistance) : r_pf_dist;
    assign start_c = r_fill - dist_c;
    assign learn_c = (r_state == ST_LEARN) && r_earlier_v && (r_earlier != cur) &&
                     !r_srd.succ_valid;

    // memory address of the current step
    logic [HistIdxW-1:0] rd_slot;
    logic [HAddrW-1:0]   rd_addr;
    logic [HAddrW-1:0]   wr_addr;
    logic                mem_we;
    logic [HistIdxW-1:0] sum_idx;

    always_comb begin
        if (r_state == ST_RD) begin
            sum_idx = r_so + r_i[HistIdxW-1:0];
            rd_addr = {r_succ, sum_idx};
        end else begin
            sum_idx = r_old + r_i[HistIdxW-1:0];
            rd_addr = {cur, sum_idx};
        end
        rd_slot = r_old + r_cnt[HistIdxW-1:0];
        wr_addr = {cur, rd_slot};
        mem_we = (r_state == ST_WRITE);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hmem[wr_addr] <= {r_req.page_address, r_req.domain_id};
        end
        r_hrd <= r_hmem[rd_addr];
    end

    // source table port: read the entry the next state needs, one write a cycle
    logic [SrcW-1:0] s_rd_addr;
    logic [SrcW-1:0] s_wr_addr;
    logic            s_we;
    t_smeta          s_wdata;

    always_comb begin
        unique case (r_state)
            ST_IDLE:  s_rd_addr = i_req.source_id;
            ST_WRITE: s_rd_addr = r_succ;
            ST_EMIT:  s_rd_addr = r_earlier;
            default:  s_rd_addr = cur;
        endcase
        s_we = 1'b0;
        s_wr_addr = cur;
        s_wdata = '0;
        if (r_state == ST_CLEAR) begin
            s_we = 1'b1;
            s_wr_addr = r_clr;
        end else if (r_state == ST_WRITE) begin
            s_we = 1'b1;
            s_wdata.succ_valid = r_made;
            s_wdata.succ_src = r_succ;
            if (r_cnt >= len_c) begin
                s_wdata.count = r_cnt;
                s_wdata.oldest = r_old + HistIdxW'(1);
            end else begin
                s_wdata.count = r_cnt + CntW'(1);
                s_wdata.oldest = r_old;
            end
        end else if (learn_c) begin
            s_we = 1'b1;
            s_wr_addr = r_earlier;
            s_wdata = r_srd;
            s_wdata.succ_valid = 1'b1;
            s_wdata.succ_src = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_smem[s_wr_addr] <= s_wdata;
        end
        r_srd <= r_smem[s_rd_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:      if (r_clr == '1) n_state = ST_IDLE;
            ST_IDLE:       if (i_req_valid) n_state = ST_META;
            ST_META:       n_state = (r_srd.count == '0) ? ST_WRITE : ST_SEARCH;
            ST_SEARCH:     n_state = ST_SEARCH_CHK;
            ST_SEARCH_CHK: begin
                if (r_hrd[PageW+DomW-1:DomW] == r_req.page_address ||
                    r_i + CntW'(1) >= r_cnt) begin
                    n_state = ST_WRITE;
                end else begin
                    n_state = ST_SEARCH;
                end
            end
            ST_WRITE:      n_state = ST_SUCC;
            ST_SUCC:       n_state = (r_made && r_srd.count != '0) ? ST_RD : ST_EMIT;
            ST_RD:         n_state = ST_LOAD;
            ST_LOAD:       n_state = ST_EMIT;
            ST_EMIT: begin
                if (!i_rsp_stall) begin
                    n_state = r_rsp.last_in_run ? ST_LEARN : ST_RD;
                end
            end
            ST_LEARN:      n_state = (r_fill >= dist_c) ? ST_SHIFT : ST_IDLE;
            ST_SHIFT:      if (r_sh + FillW'(1) >= dist_c) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_req_stall = (r_state != ST_IDLE);
        o_rsp_valid = (r_state == ST_EMIT);
        o_rsp = r_rsp;
        o_cfg_ready = (r_state == ST_IDLE);
    end

    // scalar next values
    always_comb begin
        n_i = r_i;
        n_recent = r_recent;
        n_sh = r_sh;
        n_clr = r_clr;
        n_fill = r_fill;
        n_earlier = r_earlier;
        n_earlier_v = r_earlier_v;
        n_pend = r_pend;
        n_pend_v = r_pend_v;
        unique case (r_state)
            ST_CLEAR: n_clr = r_clr + SrcW'(1);
            ST_META: begin
                n_i = '0;
                n_recent = 1'b0;
            end
            ST_SEARCH_CHK: begin
                if (r_hrd[PageW+DomW-1:DomW] == r_req.page_address) n_recent = 1'b1;
                n_i = r_i + CntW'(1);
            end
            ST_SUCC: begin
                n_i = '0;
                n_pend = r_succ;
                n_pend_v = r_made;
            end
            ST_EMIT: if (!i_rsp_stall) n_i = r_i + CntW'(1);
            ST_LEARN: begin
                n_sh = '0;
                if (r_fill >= dist_c) begin
                    n_earlier = r_fifo[start_c[FifoIdxW-1:0]];
                    n_earlier_v = 1'b1;
                    n_fill = dist_c;
                end else begin
                    n_fill = r_fill + FillW'(1);
                end
            end
            ST_SHIFT: n_sh = r_sh + FillW'(1);
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr <= '0;
            r_hist_len <= CntW'(4);
            r_pf_dist <= FillW'(1);
            r_fill <= '0;
            r_earlier <= '0;
            r_earlier_v <= 1'b0;
            r_pend <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_fill <= n_fill;
            r_earlier <= n_earlier;
            r_earlier_v <= n_earlier_v;
            r_pend <= n_pend;
            r_pend_v <= n_pend_v;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CfgHistoryLength) r_hist_len <= i_cfg_data[CntW-1:0];
                else r_pf_dist <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_recent <= n_recent;
        r_sh <= n_sh;
        if (r_state == ST_IDLE) begin
            r_req <= i_req;
        end
        if (r_state == ST_META) begin
            r_cnt <= r_srd.count;
            r_old <= r_srd.oldest;
            r_prior <= r_pend_v ? ((r_pend == cur) ? PriorHit : PriorMiss) : PriorNone;
            r_made <= r_srd.succ_valid;
            r_succ <= r_srd.succ_valid ? r_srd.succ_src : '0;
        end
        if (r_state == ST_SUCC) begin
            r_sc <= (r_srd.count > CntW'(MaxHistory)) ? CntW'(MaxHistory) : r_srd.count;
            r_so <= r_srd.oldest;
            r_rsp.prediction_made <= r_made;
            r_rsp.predicted_source <= r_succ;
            r_rsp.prefetch_page <= '0;
            r_rsp.prefetch_domain <= '0;
            r_rsp.last_in_run <= 1'b1;
            r_rsp.page_was_recent <= r_recent;
            r_rsp.prior_prediction <= r_prior;
        end
        if (r_state == ST_RD) begin
            r_rsp.last_in_run <= (r_i + CntW'(1) == r_sc);
        end
        // read data has landed; show it from the emit state on
        if (r_state == ST_LOAD) begin
            r_rsp.prefetch_page <= r_hrd[PageW+DomW-1:DomW];
            r_rsp.prefetch_domain <= r_hrd[DomW-1:0];
        end
        if (r_state == ST_LEARN) begin
            r_start <= start_c;
            if (r_fill < dist_c) r_fifo[r_fill[FifoIdxW-1:0]] <= cur;
        end
        if (r_state == ST_SHIFT) begin
            if (r_sh + FillW'(1) >= dist_c) begin
                r_fifo[r_sh[FifoIdxW-1:0]] <= cur;
            end else begin
                r_fifo[r_sh[FifoIdxW-1:0]] <= r_fifo[FifoIdxW'(r_start + r_sh + FillW'(1))];
            end
        end
    end

    // assertions
    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_req_stall) else $error("result while idle");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_rsp_valid) else $error("cfg during work");
    a_made_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.prediction_made) |-> o_rsp.last_in_run)
        else $error("no-prediction run too long");

endmodule
